// File: design/dsil_pkg.sv
// ----------------------------------------------------------------------------
// dsil_pkg
// shared widths, codes and sequencer states of the dense set core
// ----------------------------------------------------------------------------
package dsil_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOCHANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_READ_LAST,
      ST_MOVE,
      ST_RESULT
   } state_type;

endpackage

// File: design/dsil_if.sv
// ----------------------------------------------------------------------------
// dsil_req_if / dsil_rsp_if
// valid/ready channels for command and result transactions
// ----------------------------------------------------------------------------
interface dsil_req_if;
   import dsil_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dsil_rsp_if;
   import dsil_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [SLOT_W-1:0]   slot_index;
   logic [STATUS_W-1:0] status;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output found, output slot_index, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input found, input slot_index, input status,
                   input occupancy, output ready);
endinterface

// File: design/dsil_ram.sv
// ----------------------------------------------------------------------------
// dsil_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dsil_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/dense_set_with_index_lookup_core.sv
// ----------------------------------------------------------------------------
// dense_set_with_index_lookup_core
// dense set of signed 32-bit values with slot lookup, held in one ram
// ----------------------------------------------------------------------------
// req_ch carries one command transaction (insert, remove, search) with its
// value; rsp_ch returns one result transaction per command: found flag, slot
// index, status and occupancy after the command.
// values sit in ram slots 0 to count-1 without gaps. each command scans the
// valid slots through the single ram read port, one slot per cycle; a remove
// that hits then reads the last slot and writes it back into the freed slot.
// one command is in work at a time; req_ch.ready is high only while the
// sequencer is idle, so a new command waits until the last one is finished.
// the result sits in an output register, so the next command is accepted
// while a result still waits; if rsp_ch stalls the sequencer holds its
// finished result until the register frees up.
// reset empties the set at once (count to zero); ram contents are never
// read above the count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dense_set_with_index_lookup_core (
   input logic          clock,
   input logic          reset,
   dsil_req_if.sink     req_ch,
   dsil_rsp_if.source   rsp_ch
);
   import dsil_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    issue_addr_ff;
   logic                cmp_valid_ff;
   logic [IDX_W-1:0]    cmp_addr_ff;
   logic                hit_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [VALUE_W-1:0]  value_ff;

   logic                res_found_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic [STATUS_W-1:0] res_status_ff;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [OCC_W-1:0]    rsp_occ_ff;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]  rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   logic                accept;
   logic                rsp_free;
   logic                full;
   logic                known_cmd;
   logic [CNT_W-1:0]    last_slot;

   assign accept    = req_ch.valid && req_ch.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign full      = count_ff >= CNT_W'(CAPACITY);
   assign known_cmd = cmd_ff inside {CMD_INSERT, CMD_REMOVE, CMD_SEARCH};
   assign last_slot = count_ff - CNT_W'(1);

   dsil_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_en && !cmp_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_REMOVE && hit_ff) begin
               state_in = ST_READ_LAST;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_READ_LAST: state_in = ST_MOVE;
         ST_MOVE:      state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = issue_addr_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = value_ff;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_SCAN: rd_en = issue_addr_ff < count_ff;
         ST_DECIDE: begin
            wr_en = cmd_ff == CMD_INSERT && !hit_ff && !full;
         end
         ST_READ_LAST: begin
            rd_en   = 1'b1;
            rd_addr = last_slot[IDX_W-1:0];
         end
         ST_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_valid_ff <= (state_ff == ST_SCAN) && rd_en;
         if (state_ff == ST_DECIDE && wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (state_ff == ST_MOVE) begin
            count_ff <= last_slot;
         end
         if (state_ff == ST_RESULT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_ch.cmd;
         value_ff      <= $unsigned(req_ch.value);
         issue_addr_ff <= '0;
         hit_ff        <= 1'b0;
         pos_ff        <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (rd_en) begin
            issue_addr_ff <= issue_addr_ff + CNT_W'(1);
         end
         cmp_addr_ff <= issue_addr_ff[IDX_W-1:0];
         if (cmp_valid_ff && !hit_ff && rd_data == value_ff) begin
            hit_ff <= 1'b1;
            pos_ff <= cmp_addr_ff;
         end
      end
      if (state_ff == ST_DECIDE) begin
         res_found_ff <= hit_ff && known_cmd;
         res_slot_ff  <= (hit_ff && known_cmd) ? SLOT_W'(pos_ff) : '0;
         case (cmd_ff)
            CMD_INSERT: begin
               if (hit_ff) begin
                  res_status_ff <= STATUS_NOCHANGE;
               end else if (full) begin
                  res_status_ff <= STATUS_FULL;
               end else begin
                  res_status_ff <= STATUS_DONE;
               end
            end
            CMD_REMOVE: res_status_ff <= hit_ff ? STATUS_DONE : STATUS_NOCHANGE;
            CMD_SEARCH: res_status_ff <= STATUS_DONE;
            default:    res_status_ff <= STATUS_NOCHANGE;
         endcase
      end
      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_found_ff  <= res_found_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
         rsp_occ_ff    <= OCC_W'(count_ff);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;

endmodule

// File: bench/tb_dense_set_with_index_lookup_core.sv
// ----------------------------------------------------------------------------
// tb_dense_set_with_index_lookup_core
// self-checking bench for the dense set core with slot lookup
// ----------------------------------------------------------------------------
// a short table of directed commands covers the empty store, both value
// extremes, a present insert, an absent remove, the unused command code, a full
// store and removal of the first and last slots. random commands follow, drawn
// mostly from a small pool of values so hits, fills to capacity and drains all
// happen often. each result is compared field by field with the table outcome
// for typed directed rows, else with a behavioral model of the set in the bench.
// both channels idle in short random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module tb_dense_set_with_index_lookup_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dsil_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RAND_ITEMS  = 900;
   localparam int CALM_ITEMS  = 150;
   localparam int POOL_SIZE   = 24;
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    occ;
   } outcome_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic               typed;
      outcome_type        outcome;
   } step_row_type;

   localparam int N_STEPS = 29;
   localparam step_row_type DIRECTED_STEPS [0:N_STEPS-1] = '{
      '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd0}},
      '{CMD_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 4'd0, STATUS_NOCHANGE, 5'd0}},
      '{CMD_UNUSED, 32'h0000_0007, 1'b1, '{1'b0, 4'd0, STATUS_NOCHANGE, 5'd0}},
      '{CMD_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd1}},
      '{CMD_INSERT, 32'h7fff_ffff, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd2}},
      '{CMD_INSERT, 32'hffff_ffff, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd3}},
      '{CMD_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd4}},
      '{CMD_INSERT, 32'hffff_ffff, 1'b1, '{1'b1, 4'd2, STATUS_NOCHANGE, 5'd4}},
      '{CMD_SEARCH, 32'h7fff_ffff, 1'b1, '{1'b1, 4'd1, STATUS_DONE,     5'd4}},
      '{CMD_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, STATUS_DONE,     5'd3}},
      '{CMD_SEARCH, 32'h0000_0000, 1'b0, '0},
      '{CMD_UNUSED, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, STATUS_NOCHANGE, 5'd3}},
      '{CMD_INSERT, 32'h0000_0001, 1'b0, '0},
      '{CMD_INSERT, 32'h0000_0002, 1'b0, '0},
      '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
      '{CMD_INSERT, 32'haaaa_aaaa, 1'b0, '0},
      '{CMD_INSERT, 32'h1234_5678, 1'b0, '0},
      '{CMD_INSERT, 32'h8765_4321, 1'b0, '0},
      '{CMD_INSERT, 32'hffff_fffe, 1'b0, '0},
      '{CMD_INSERT, 32'h8000_0001, 1'b0, '0},
      '{CMD_INSERT, 32'h7fff_fffe, 1'b0, '0},
      '{CMD_INSERT, 32'h0000_0100, 1'b0, '0},
      '{CMD_INSERT, 32'hdead_beef, 1'b0, '0},
      '{CMD_INSERT, 32'h0f0f_0f0f, 1'b0, '0},
      '{CMD_INSERT, 32'hf0f0_f0f0, 1'b0, '0},
      '{CMD_INSERT, 32'h0000_0003, 1'b1, '{1'b0, 4'd0, STATUS_FULL,     5'd16}},
      '{CMD_REMOVE, 32'hf0f0_f0f0, 1'b0, '0},
      '{CMD_REMOVE, 32'h0000_0000, 1'b0, '0},
      '{CMD_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, STATUS_DONE,     5'd14}}
   };

   logic clock = 1'b0;
   logic reset;

   dsil_req_if req_ch ();
   dsil_rsp_if rsp_ch ();

   dense_set_with_index_lookup_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model of the set contents
   logic [VALUE_W-1:0] set_slots [CAPACITY];
   int                 set_count;

   outcome_type        outcome_q [$];
   logic [VALUE_W-1:0] value_pool [POOL_SIZE];
   bit                 idle_on;
   int                 cycle_count;
   int                 err_count;
   int                 n_checked, n_insert, n_remove, n_search, n_unused;
   int                 n_hits, n_full, peak_occ;

   function automatic outcome_type apply_set_cmd(logic [CMD_W-1:0] cmd,
                                                 logic [VALUE_W-1:0] v);
      outcome_type o;
      bit          hit;
      int          pos;
      hit = 1'b0;
      pos = 0;
      for (int i = 0; i < set_count; i++) begin
         if (!hit && set_slots[i] == v) begin
            hit = 1'b1;
            pos = i;
         end
      end
      o.found  = hit;
      o.slot   = hit ? pos[SLOT_W-1:0] : '0;
      o.status = STATUS_NOCHANGE;
      case (cmd)
         CMD_INSERT: begin
            if (hit) begin
               o.status = STATUS_NOCHANGE;
            end else if (set_count >= CAPACITY) begin
               o.status = STATUS_FULL;
            end else begin
               set_slots[set_count] = v;
               set_count++;
               o.status = STATUS_DONE;
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               set_slots[pos] = set_slots[set_count-1];
               set_count--;
               o.status = STATUS_DONE;
            end
         end
         CMD_SEARCH: begin
            o.status = STATUS_DONE;
         end
         default: begin
            o.found  = 1'b0;
            o.slot   = '0;
            o.status = STATUS_NOCHANGE;
         end
      endcase
      o.occ = set_count[OCC_W-1:0];
      return o;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return $urandom;
      end else if (r < 16) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      end
      return value_pool[$urandom_range(0, POOL_SIZE-1)];
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return CMD_UNUSED;
      end else if (r < (filling ? 58 : 23)) begin
         return CMD_INSERT;
      end else if (r < (filling ? 78 : 68)) begin
         return CMD_REMOVE;
      end
      return CMD_SEARCH;
   endfunction

   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v,
                           bit typed, outcome_type typed_outcome);
      outcome_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_set_cmd(cmd, v);
      case (cmd)
         CMD_INSERT: n_insert++;
         CMD_REMOVE: n_remove++;
         CMD_SEARCH: n_search++;
         default:    n_unused++;
      endcase
      if (predicted.found) n_hits++;
      if (predicted.status == STATUS_FULL) n_full++;
      if (set_count > peak_occ) peak_occ = set_count;
      if (typed) predicted = typed_outcome;
      outcome_q = {outcome_q, predicted};
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               outcome_q.size());
      $display("dense_set_with_index_lookup_core test failed");
      $finish;
   end

   // result side: random stall bursts, checks each transaction
   initial begin
      int          stall_left;
      outcome_type want;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               $error("result transaction with nothing expected");
               err_count++;
            end else begin
               want = outcome_q.pop_front();
               n_checked++;
               if (rsp_ch.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                  err_count++;
               end
               if (rsp_ch.slot_index !== want.slot) begin
                  $error("slot_index: expected %0d, actual %0d", want.slot,
                         rsp_ch.slot_index);
                  err_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  err_count++;
               end
               if (rsp_ch.occupancy !== want.occ) begin
                  $error("occupancy: expected %0d, actual %0d", want.occ,
                         rsp_ch.occupancy);
                  err_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      bit filling;
      int phase_left;
      n_insert    = 0;
      n_remove    = 0;
      n_search    = 0;
      n_unused    = 0;
      n_hits      = 0;
      n_full      = 0;
      peak_occ    = 0;
      set_count   = 0;
      idle_on     = 1'b1;
      filling     = 1'b1;
      phase_left  = $urandom_range(30, 80);
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_SEARCH;
      req_ch.value <= '0;
      for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < N_STEPS; k++) begin
         send_cmd(DIRECTED_STEPS[k].cmd, DIRECTED_STEPS[k].value,
                  DIRECTED_STEPS[k].typed, DIRECTED_STEPS[k].outcome);
      end

      // alternate fill-heavy and drain-heavy stretches
      for (int k = 0; k < RAND_ITEMS; k++) begin
         idle_on = (k < RAND_ITEMS - CALM_ITEMS);
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(30, 80);
         end
         phase_left--;
         send_cmd(pick_cmd(filling), pick_value(), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("%0d results checked: %0d inserts, %0d removes, %0d searches, %0d unused",
               n_checked, n_insert, n_remove, n_search, n_unused);
      $display("%0d hits, %0d refused on full store, peak occupancy %0d",
               n_hits, n_full, peak_occ);
      if (err_count == 0 && outcome_q.size() == 0) begin
         $display("dense_set_with_index_lookup_core test passed");
      end else begin
         $display("dense_set_with_index_lookup_core test failed");
      end
      $finish;
   end

endmodule
